>>> hw/rtl/mfpr_pkg.sv
// Shared types and codes for the push-relabel maximum-flow block.
package mfpr_pkg;

    // Input actions.
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_RUN   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [1:0] CFG_SOURCE     = 2'd1;
    localparam logic [1:0] CFG_SINK       = 2'd2;

    // Fixed field widths.
    localparam int FLOW_OUT_W = 20;
    localparam int CFG_W      = 5;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAP_WRITE,
        OP_SWEEP_START,
        OP_SWEEP,
        OP_RUN_INIT,
        OP_ERR,
        OP_BUILD,
        OP_SRC_INIT,
        OP_RD,
        OP_PUSH1,
        OP_PUSH2,
        OP_B_INC,
        OP_WRITE_BACK,
        OP_LOAD,
        OP_STORE,
        OP_B_FROM_PTR,
        OP_PTR_INC,
        OP_LIFT_INIT,
        OP_LIFT_EVAL,
        OP_LIFT_DONE,
        OP_SUM_INIT,
        OP_SUM_ACC,
        OP_RESULT
    } t_op;

    // Command from controller to datapath.
    typedef struct packed {
        t_op op;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic cfg_ok;
        logic sweep_last;
        logic sweep_cap;
        logic build_last;
        logic edge_ok;
        logic push_ok;
        logic b_last;
        logic k_lt_len;
        logic ea_zero;
        logic pa_lt_n;
    } t_status;

endpackage

>>> hw/rtl/max_flow_push_relabel.sv
// Top level of the push-relabel maximum-flow block.
//
//  channel   dir  handshake            payload
//  input     in   i_valid / o_stall    i_action, i_from_node, i_to_node, i_capacity
//  result    out  o_valid / i_stall    o_max_flow, o_status
//  config    in   i_cfg_we             i_cfg_idx, i_cfg_data
//
// An edge write is stored and an unused action is dropped without leaving idle.
// A clear beat and reset run a clearing pass over MAX_NODES rounded up to a
// power of two, squared, memory entries (256 at the defaults) with input stalled.
// A run builds the node list and clears the flow memory with the same pass,
// then does the sequential discharge and relabel scans, one RAM read per
// edge look-up over one read port; the run time depends on the graph.
// Input beats are stalled during a run; a finished result waits in the
// output register and the next beat is taken while it waits.
module max_flow_push_relabel #(
    parameter int MAX_NODES = 16,
    parameter int CAP_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_from_node,
    input  logic [3:0]  i_to_node,
    input  logic [15:0] i_capacity,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [19:0] o_max_flow,
    output logic        o_status,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data
);

    mfpr_pkg::t_cmd    cmd;
    mfpr_pkg::t_status status;

    mfpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_action    (i_action),
        .i_out_stall (i_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid)
    );

    mfpr_dp #(.MAX_NODES(MAX_NODES), .CAP_WIDTH(CAP_WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_from_node (i_from_node),
        .i_to_node   (i_to_node),
        .i_capacity  (i_capacity),
        .o_status    (status),
        .o_max_flow  (o_max_flow),
        .o_err       (o_status)
    );

endmodule

>>> hw/rtl/mfpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mfpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/mfpr_ctrl.sv
// Controller state machine that sequences loads, clears and flow runs.
module mfpr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_action,
    input  logic               i_out_stall,
    input  mfpr_pkg::t_status  i_status,
    output mfpr_pkg::t_cmd     o_cmd,
    output logic               o_in_stall,
    output logic               o_out_valid
);

    typedef enum logic [4:0] {
        S_SWEEP,
        S_IDLE,
        S_BUILD,
        S_SRC_INIT,
        S_SRC_RD,
        S_SRC_EVAL,
        S_SRC_PUSH2,
        S_SRC_NEXT,
        S_NODE_CHK,
        S_CHECK,
        S_RD,
        S_EVAL,
        S_PUSH2,
        S_LIFT_RD,
        S_LIFT_EVAL,
        S_LIFT_DONE,
        S_SUM_RD,
        S_SUM_ACC,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    mfpr_pkg::t_op op;
    logic   in_beat;
    logic   out_free;

    assign in_beat  = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state and the operation for this cycle.
    always_comb begin
        n_state     = r_state;
        op          = mfpr_pkg::OP_NONE;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_SWEEP: begin
                op = mfpr_pkg::OP_SWEEP;
                if (i_status.sweep_last) begin
                    n_state = i_status.sweep_cap ? S_IDLE : S_SRC_INIT;
                end
            end
            S_IDLE: begin
                if (in_beat) begin
                    case (i_action)
                        mfpr_pkg::ACT_WRITE: op = mfpr_pkg::OP_CAP_WRITE;
                        mfpr_pkg::ACT_CLEAR: begin
                            op      = mfpr_pkg::OP_SWEEP_START;
                            n_state = S_SWEEP;
                        end
                        mfpr_pkg::ACT_RUN: begin
                            if (i_status.cfg_ok) begin
                                op      = mfpr_pkg::OP_RUN_INIT;
                                n_state = S_BUILD;
                            end else begin
                                op      = mfpr_pkg::OP_ERR;
                                n_state = S_DONE;
                            end
                        end
                        default: op = mfpr_pkg::OP_NONE;
                    endcase
                end
            end
            S_BUILD: begin
                op = mfpr_pkg::OP_BUILD;
                if (i_status.build_last) begin
                    n_state = S_SWEEP;
                end
            end
            S_SRC_INIT: begin
                op      = mfpr_pkg::OP_SRC_INIT;
                n_state = S_SRC_RD;
            end
            S_SRC_RD: begin
                op      = mfpr_pkg::OP_RD;
                n_state = S_SRC_EVAL;
            end
            S_SRC_EVAL: begin
                if (i_status.edge_ok) begin
                    op      = mfpr_pkg::OP_PUSH1;
                    n_state = S_SRC_PUSH2;
                end else begin
                    n_state = S_SRC_NEXT;
                end
            end
            S_SRC_PUSH2: begin
                op      = mfpr_pkg::OP_PUSH2;
                n_state = S_SRC_NEXT;
            end
            S_SRC_NEXT: begin
                if (i_status.b_last) begin
                    op      = mfpr_pkg::OP_WRITE_BACK;
                    n_state = S_NODE_CHK;
                end else begin
                    op      = mfpr_pkg::OP_B_INC;
                    n_state = S_SRC_RD;
                end
            end
            S_NODE_CHK: begin
                if (i_status.k_lt_len) begin
                    op      = mfpr_pkg::OP_LOAD;
                    n_state = S_CHECK;
                end else begin
                    op      = mfpr_pkg::OP_SUM_INIT;
                    n_state = S_SUM_RD;
                end
            end
            S_CHECK: begin
                if (i_status.ea_zero) begin
                    op      = mfpr_pkg::OP_STORE;
                    n_state = S_NODE_CHK;
                end else if (i_status.pa_lt_n) begin
                    op      = mfpr_pkg::OP_B_FROM_PTR;
                    n_state = S_RD;
                end else begin
                    op      = mfpr_pkg::OP_LIFT_INIT;
                    n_state = S_LIFT_RD;
                end
            end
            S_RD: begin
                op      = mfpr_pkg::OP_RD;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_status.push_ok) begin
                    op      = mfpr_pkg::OP_PUSH1;
                    n_state = S_PUSH2;
                end else begin
                    op      = mfpr_pkg::OP_PTR_INC;
                    n_state = S_CHECK;
                end
            end
            S_PUSH2: begin
                op      = mfpr_pkg::OP_PUSH2;
                n_state = S_CHECK;
            end
            S_LIFT_RD: begin
                op      = mfpr_pkg::OP_RD;
                n_state = S_LIFT_EVAL;
            end
            S_LIFT_EVAL: begin
                op      = mfpr_pkg::OP_LIFT_EVAL;
                n_state = i_status.b_last ? S_LIFT_DONE : S_LIFT_RD;
            end
            S_LIFT_DONE: begin
                op      = mfpr_pkg::OP_LIFT_DONE;
                n_state = S_CHECK;
            end
            S_SUM_RD: begin
                op      = mfpr_pkg::OP_RD;
                n_state = S_SUM_ACC;
            end
            S_SUM_ACC: begin
                op      = mfpr_pkg::OP_SUM_ACC;
                n_state = i_status.b_last ? S_DONE : S_SUM_RD;
            end
            S_DONE: begin
                if (out_free) begin
                    op          = mfpr_pkg::OP_RESULT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and output valid; reset starts with a clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd.op    = op;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> hw/rtl/mfpr_dp.sv
// Datapath: capacity and flow memories, node arrays and push-relabel arithmetic.
module mfpr_dp #(
    parameter int MAX_NODES = 16,
    parameter int CAP_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mfpr_pkg::t_cmd                      i_cmd,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_idx,
    input  logic [mfpr_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic [3:0]                          i_from_node,
    input  logic [3:0]                          i_to_node,
    input  logic [15:0]                         i_capacity,
    output mfpr_pkg::t_status                   o_status,
    output logic [mfpr_pkg::FLOW_OUT_W-1:0]     o_max_flow,
    output logic                                o_err
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int HW    = $clog2(2 * MAX_NODES) + 1;
    localparam int AW    = 2 * NW;
    localparam int DEPTH = 1 << AW;
    localparam int EXW   = CAP_WIDTH + 5;
    localparam int FW    = CAP_WIDTH + 1;
    localparam int RW    = CAP_WIDTH + 2;
    localparam int TW    = FW + NW + 1;

    // Configuration registers.
    logic [4:0] r_node_count;
    logic [3:0] r_source;
    logic [3:0] r_sink;

    // Control counters.
    logic [AW-1:0] r_sweep;
    logic          r_sweep_cap;

    // Node arrays.
    logic [HW-1:0]  r_height [MAX_NODES];
    logic [EXW-1:0] r_excess [MAX_NODES];
    logic [CW-1:0]  r_ptr    [MAX_NODES];
    logic [NW-1:0]  r_order  [MAX_NODES];

    // Working registers.
    logic [CW-1:0]  r_n;
    logic [NW-1:0]  r_s;
    logic [NW-1:0]  r_t;
    logic [NW-1:0]  r_i;
    logic [CW-1:0]  r_len;
    logic [CW-1:0]  r_k;
    logic [NW-1:0]  r_a;
    logic [NW-1:0]  r_b;
    logic [HW-1:0]  r_ha;
    logic [HW-1:0]  r_hbefore;
    logic [HW-1:0]  r_hb;
    logic [EXW-1:0] r_ea;
    logic [CW-1:0]  r_pa;
    logic [HW-1:0]  r_best;
    logic           r_best_ok;
    logic [FW-1:0]  r_nf;
    logic [FW-1:0]  r_amt;
    logic [TW-1:0]  r_total;
    logic           r_err;
    logic           r_status;
    logic [mfpr_pkg::FLOW_OUT_W-1:0] r_max_flow;

    // Memory ports.
    logic             cap_we;
    logic [AW-1:0]    cap_waddr;
    logic [CAP_WIDTH-1:0] cap_wdata;
    logic [CAP_WIDTH-1:0] cap_rd;
    logic             flow_we;
    logic [AW-1:0]    flow_waddr;
    logic [FW-1:0]    flow_wdata;
    logic [FW-1:0]    flow_rd;

    logic          edge_in_range;
    logic [RW-1:0] resid;
    logic          resid_pos;
    logic [FW-1:0] room;
    logic [FW-1:0] amt;
    logic [FW-1:0] nf;
    logic          cfg_ok;
    logic [NW-1:0] a_load;
    mfpr_pkg::t_op op;

    assign op = i_cmd.op;

    // Edge writes beyond the node array are dropped.
    assign edge_in_range = (int'(i_from_node) < MAX_NODES) && (int'(i_to_node) < MAX_NODES);

    // Residual capacity of edge (a, b) and the amount a push moves.
    assign resid     = $signed({2'b00, cap_rd}) - $signed({flow_rd[FW-1], flow_rd});
    assign resid_pos = $signed(resid) > $signed(RW'(0));
    assign room      = resid[FW-1:0];
    assign amt       = ({{(EXW - FW){1'b0}}, room} < r_ea) ? room : r_ea[FW-1:0];
    assign nf        = FW'({flow_rd[FW-1], flow_rd} + {1'b0, amt});

    // Configuration check for a run.
    assign cfg_ok = (r_node_count >= 5'd2) && (int'(r_node_count) <= MAX_NODES)
                 && (r_source != r_sink)
                 && ({1'b0, r_source} < r_node_count)
                 && ({1'b0, r_sink} < r_node_count);

    assign a_load = r_order[NW'(r_k)];

    // Memory port selection.
    always_comb begin
        cap_we     = 1'b0;
        cap_waddr  = {NW'(i_from_node), NW'(i_to_node)};
        cap_wdata  = CAP_WIDTH'(i_capacity);
        flow_we    = 1'b0;
        flow_waddr = {r_a, r_b};
        flow_wdata = nf;
        case (op)
            mfpr_pkg::OP_CAP_WRITE: cap_we = edge_in_range;
            mfpr_pkg::OP_SWEEP: begin
                cap_we     = r_sweep_cap;
                cap_waddr  = r_sweep;
                cap_wdata  = '0;
                flow_we    = 1'b1;
                flow_waddr = r_sweep;
                flow_wdata = '0;
            end
            mfpr_pkg::OP_PUSH1: flow_we = 1'b1;
            mfpr_pkg::OP_PUSH2: begin
                flow_we    = 1'b1;
                flow_waddr = {r_b, r_a};
                flow_wdata = FW'(-$signed(r_nf));
            end
            default: cap_we = 1'b0;
        endcase
    end

    mfpr_ram #(.WIDTH(CAP_WIDTH), .DEPTH(DEPTH)) u_cap_ram (
        .i_clk   (i_clk),
        .i_we    (cap_we),
        .i_waddr (cap_waddr),
        .i_wdata (cap_wdata),
        .i_raddr ({r_a, r_b}),
        .o_rdata (cap_rd)
    );

    mfpr_ram #(.WIDTH(FW), .DEPTH(DEPTH)) u_flow_ram (
        .i_clk   (i_clk),
        .i_we    (flow_we),
        .i_waddr (flow_waddr),
        .i_wdata (flow_wdata),
        .i_raddr ({r_a, r_b}),
        .o_rdata (flow_rd)
    );

    // Configuration registers and clearing-pass control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 5'd16;
            r_source     <= 4'd0;
            r_sink       <= 4'd15;
            r_sweep      <= '0;
            r_sweep_cap  <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mfpr_pkg::CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                    mfpr_pkg::CFG_SOURCE:     r_source     <= i_cfg_data[3:0];
                    mfpr_pkg::CFG_SINK:       r_sink       <= i_cfg_data[3:0];
                    default:                  r_node_count <= r_node_count;
                endcase
            end
            case (op)
                mfpr_pkg::OP_SWEEP_START: begin
                    r_sweep     <= '0;
                    r_sweep_cap <= 1'b1;
                end
                mfpr_pkg::OP_RUN_INIT: begin
                    r_sweep     <= '0;
                    r_sweep_cap <= 1'b0;
                end
                mfpr_pkg::OP_SWEEP: r_sweep <= r_sweep + 1'b1;
                default:            r_sweep <= r_sweep;
            endcase
        end
    end

    // Push-relabel working state.
    always_ff @(posedge i_clk) begin
        case (op)
            mfpr_pkg::OP_RUN_INIT: begin
                r_n     <= CW'(r_node_count);
                r_s     <= NW'(r_source);
                r_t     <= NW'(r_sink);
                r_i     <= '0;
                r_len   <= '0;
                r_k     <= '0;
                r_err   <= 1'b0;
                for (int j = 0; j < MAX_NODES; j++) begin
                    r_height[j] <= '0;
                    r_excess[j] <= '0;
                    r_ptr[j]    <= '0;
                end
                r_height[NW'(r_source)] <= HW'(r_node_count);
                r_excess[NW'(r_source)] <= {EXW{1'b1}};
            end
            mfpr_pkg::OP_ERR: begin
                r_err   <= 1'b1;
                r_total <= '0;
            end
            mfpr_pkg::OP_BUILD: begin
                if (r_i != r_s && r_i != r_t) begin
                    r_order[NW'(r_len)] <= r_i;
                    r_len               <= r_len + 1'b1;
                end
                r_i <= r_i + 1'b1;
            end
            mfpr_pkg::OP_SRC_INIT: begin
                r_a  <= r_s;
                r_b  <= '0;
                r_ea <= {EXW{1'b1}};
                r_ha <= HW'(r_n);
                r_pa <= '0;
            end
            mfpr_pkg::OP_RD: r_hb <= r_height[r_b];
            mfpr_pkg::OP_PUSH1: begin
                r_nf  <= nf;
                r_amt <= amt;
                r_ea  <= r_ea - EXW'(amt);
            end
            mfpr_pkg::OP_PUSH2: r_excess[r_b] <= r_excess[r_b] + EXW'(r_amt);
            mfpr_pkg::OP_B_INC: r_b <= r_b + 1'b1;
            mfpr_pkg::OP_WRITE_BACK: begin
                r_excess[r_a] <= r_ea;
                r_height[r_a] <= r_ha;
                r_ptr[r_a]    <= r_pa;
            end
            mfpr_pkg::OP_LOAD: begin
                r_a       <= a_load;
                r_ha      <= r_height[a_load];
                r_hbefore <= r_height[a_load];
                r_ea      <= r_excess[a_load];
                r_pa      <= r_ptr[a_load];
            end
            mfpr_pkg::OP_STORE: begin
                r_excess[r_a] <= r_ea;
                r_height[r_a] <= r_ha;
                r_ptr[r_a]    <= r_pa;
                // A node that rose moves to the front of the list.
                if (r_ha > r_hbefore) begin
                    for (int j = 1; j < MAX_NODES; j++) begin
                        if (CW'(j) <= r_k) begin
                            r_order[j] <= r_order[j-1];
                        end
                    end
                    r_order[0] <= r_a;
                    r_k        <= '0;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            mfpr_pkg::OP_B_FROM_PTR: r_b <= NW'(r_pa);
            mfpr_pkg::OP_PTR_INC:    r_pa <= r_pa + 1'b1;
            mfpr_pkg::OP_LIFT_INIT: begin
                r_b       <= '0;
                r_best_ok <= 1'b0;
            end
            mfpr_pkg::OP_LIFT_EVAL: begin
                if (r_b != r_a && resid_pos && (!r_best_ok || r_hb < r_best)) begin
                    r_best    <= r_hb;
                    r_best_ok <= 1'b1;
                end
                r_b <= r_b + 1'b1;
            end
            mfpr_pkg::OP_LIFT_DONE: begin
                if (r_best_ok) begin
                    r_ha <= r_best + 1'b1;
                end
                r_pa <= '0;
            end
            mfpr_pkg::OP_SUM_INIT: begin
                r_a     <= r_s;
                r_b     <= '0;
                r_total <= '0;
            end
            mfpr_pkg::OP_SUM_ACC: begin
                r_total <= r_total + TW'($signed(flow_rd));
                r_b     <= r_b + 1'b1;
            end
            mfpr_pkg::OP_RESULT: begin
                r_status <= r_err;
                if (r_err || r_total[TW-1]) begin
                    r_max_flow <= '0;
                end else begin
                    r_max_flow <= mfpr_pkg::FLOW_OUT_W'($unsigned(r_total));
                end
            end
            default: r_b <= r_b;
        endcase
    end

    // Status toward the controller.
    assign o_status.cfg_ok     = cfg_ok;
    assign o_status.sweep_last = (r_sweep == {AW{1'b1}});
    assign o_status.sweep_cap  = r_sweep_cap;
    assign o_status.build_last = (r_i == NW'(r_n - 1'b1));
    assign o_status.edge_ok    = (r_b != r_a) && resid_pos;
    assign o_status.push_ok    = (r_b != r_a) && resid_pos && (r_ha > r_hb);
    assign o_status.b_last     = (r_b == NW'(r_n - 1'b1));
    assign o_status.k_lt_len   = (r_k < r_len);
    assign o_status.ea_zero    = (r_ea == '0);
    assign o_status.pa_lt_n    = (r_pa < r_n);

    // Result beat fields, held until the beat is taken.
    assign o_max_flow = r_max_flow;
    assign o_err      = r_status;

endmodule

>>> dv/tb.sv
// Testbench for the push-relabel maximum-flow block with a built-in flow predictor.
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic [1:0]  action;
        logic [3:0]  from_node;
        logic [3:0]  to_node;
        logic [15:0] capacity;
    } t_edge_beat;

    typedef struct {
        logic [19:0] flow_total;
        logic        status;
    } t_flow_answer;

    // Action code that the block ignores.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_action = '0;
    logic [3:0]  i_from_node = '0;
    logic [3:0]  i_to_node = '0;
    logic [15:0] i_capacity = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [19:0] o_max_flow;
    logic        o_status;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [4:0]  i_cfg_data = '0;

    max_flow_push_relabel DUT (.*);

    t_edge_beat   pending_beats[$];
    t_flow_answer expected_flows[$];
    int           failures = 0;
    int           idle_pct = 33;
    int           quiet_cycles = 0;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 700;

    // Predictor state: configuration and graph memories.
    int n_nodes = 16;
    int src_node = 0;
    int snk_node = 15;
    int cap_mem[16][16];
    int flow_mem[16][16];
    int excess_of[16];
    int height_of[16];
    int cursor_of[16];
    int order_list[16];

    initial forever #6 i_clk = ~i_clk;

    function automatic int room(int a, int b);
        return cap_mem[a][b] - flow_mem[a][b];
    endfunction

    // Push as much excess as the residual edge allows.
    function automatic void push_excess(int a, int b);
        int amt;
        amt = (excess_of[a] < room(a, b)) ? excess_of[a] : room(a, b);
        flow_mem[a][b] += amt;
        flow_mem[b][a] -= amt;
        excess_of[a] -= amt;
        excess_of[b] += amt;
    endfunction

    // Raise a node to one above its lowest residual neighbor.
    function automatic void relabel(int a);
        int best;
        best = -1;
        for (int b = 0; b < n_nodes; b++) begin
            if (b != a && room(a, b) > 0 && (best < 0 || height_of[b] < best))
                best = height_of[b];
        end
        if (best >= 0) height_of[a] = best + 1;
    endfunction

    function automatic void discharge(int a);
        int b;
        while (excess_of[a] > 0) begin
            if (cursor_of[a] < n_nodes) begin
                b = cursor_of[a];
                if (b != a && room(a, b) > 0 && height_of[a] > height_of[b])
                    push_excess(a, b);
                else
                    cursor_of[a]++;
            end else begin
                relabel(a);
                cursor_of[a] = 0;
            end
        end
    endfunction

    // Relabel-to-front maximum flow over the stored capacities.
    function automatic t_flow_answer predict_max_flow();
        t_flow_answer ans;
        int len, k, a, old_h;
        longint total;
        ans.flow_total = '0;
        ans.status = 1'b1;
        if (n_nodes < 2 || n_nodes > 16 || src_node == snk_node ||
            src_node >= n_nodes || snk_node >= n_nodes)
            return ans;
        for (int i = 0; i < 16; i++) begin
            excess_of[i] = 0;
            height_of[i] = 0;
            cursor_of[i] = 0;
            for (int j = 0; j < 16; j++) flow_mem[i][j] = 0;
        end
        len = 0;
        for (int i = 0; i < n_nodes; i++)
            if (i != src_node && i != snk_node) begin
                order_list[len] = i;
                len++;
            end
        height_of[src_node] = n_nodes;
        excess_of[src_node] = (1 << 21) - 1;
        for (int b = 0; b < n_nodes; b++)
            if (b != src_node && cap_mem[src_node][b] > 0) push_excess(src_node, b);
        k = 0;
        while (k < len) begin
            a = order_list[k];
            old_h = height_of[a];
            discharge(a);
            if (height_of[a] > old_h) begin
                for (int i = k; i > 0; i--) order_list[i] = order_list[i - 1];
                order_list[0] = a;
                k = 0;
            end else begin
                k++;
            end
        end
        total = 0;
        for (int b = 0; b < n_nodes; b++) total += flow_mem[src_node][b];
        if (total < 0) total = 0;
        ans.flow_total = total[19:0];
        ans.status = 1'b0;
        return ans;
    endfunction

    // Update the predictor for one accepted input beat.
    function automatic void apply_beat(t_edge_beat bt);
        case (bt.action)
            mfpr_pkg::ACT_WRITE: cap_mem[bt.from_node][bt.to_node] = int'(bt.capacity);
            mfpr_pkg::ACT_RUN:
                expected_flows.insert(expected_flows.size(), predict_max_flow());
            mfpr_pkg::ACT_CLEAR: begin
                for (int i = 0; i < 16; i++)
                    for (int j = 0; j < 16; j++) cap_mem[i][j] = 0;
            end
            default: ;
        endcase
    endfunction

    // Driver: present queued beats, with random gaps.
    always @(posedge i_clk) begin
        t_edge_beat bt;
        logic       busy;
        busy = i_valid;
        if (i_rst_n && i_valid && !o_stall) begin
            apply_beat('{i_action, i_from_node, i_to_node, i_capacity});
            busy = 1'b0;
        end
        if (i_rst_n && !busy && pending_beats.size() > 0 &&
            $urandom_range(99) >= idle_pct) begin
            bt = pending_beats.pop_front();
            i_valid <= 1'b1;
            i_action <= bt.action;
            i_from_node <= bt.from_node;
            i_to_node <= bt.to_node;
            i_capacity <= bt.capacity;
        end else begin
            i_valid <= busy;
        end
    end

    // Monitor: check each result beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_flow_answer exp_a;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_flows.size() == 0) begin
                $display("%0t: unexpected result flow=%0d status=%0d",
                         $time, o_max_flow, o_status);
                failures++;
            end else begin
                exp_a = expected_flows.pop_front();
                if (o_max_flow !== exp_a.flow_total) begin
                    $display("%0t: max_flow expected %0d actual %0d",
                             $time, exp_a.flow_total, o_max_flow);
                    failures++;
                end
                if (o_status !== exp_a.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_a.status, o_status);
                    failures++;
                end
            end
        end
        i_stall <= ($urandom_range(99) < idle_pct);
    end

    // Watchdog: count cycles with no beat accepted on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_beat(logic [1:0] act, logic [3:0] f, logic [3:0] t,
                              logic [15:0] c);
        t_edge_beat bt;
        bt = '{act, f, t, c};
        pending_beats.insert(pending_beats.size(), bt);
    endtask

    // Wait until every beat is taken and every result has come back.
    task automatic wait_idle();
        while (pending_beats.size() > 0 || i_valid || expected_flows.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            mfpr_pkg::CFG_NODE_COUNT: n_nodes = int'(val);
            mfpr_pkg::CFG_SOURCE:     src_node = int'(val[3:0]);
            mfpr_pkg::CFG_SINK:       snk_node = int'(val[3:0]);
            default: ;
        endcase
    endtask

    // Random graph beats biased toward nodes in use, with runs, clears and unused actions mixed in.
    task automatic queue_random(int count);
        int r, lim;
        lim = (n_nodes >= 2 && n_nodes <= 16) ? n_nodes - 1 : 15;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 60)
                queue_beat(mfpr_pkg::ACT_WRITE,
                           ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                    : 4'($urandom_range(lim)),
                           ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                    : 4'($urandom_range(lim)),
                           ($urandom_range(3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(200)));
            else if (r < 90)
                queue_beat(mfpr_pkg::ACT_RUN, 4'($urandom), 4'($urandom), 16'($urandom));
            else if (r < 95)
                queue_beat(mfpr_pkg::ACT_CLEAR, 4'($urandom), 4'($urandom), 16'($urandom));
            else
                queue_beat(ACT_UNUSED, 4'($urandom), 4'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        automatic int cfgs[10][3] = '{'{2, 0, 1}, '{2, 1, 0}, '{16, 15, 0}, '{5, 2, 4},
                                      '{8, 3, 3}, '{4, 0, 6}, '{0, 0, 1}, '{31, 0, 15},
                                      '{1, 0, 1}, '{9, 7, 2}};
        for (int i = 0; i < 16; i++)
            for (int j = 0; j < 16; j++) cap_mem[i][j] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // Directed: extreme capacities and nodes, self loop, unused action, clear.
        queue_beat(mfpr_pkg::ACT_RUN, 4'd0, 4'd0, 16'd0);
        queue_beat(mfpr_pkg::ACT_WRITE, 4'd0, 4'd15, 16'hFFFF);
        queue_beat(mfpr_pkg::ACT_RUN, 4'd0, 4'd0, 16'd0);
        queue_beat(mfpr_pkg::ACT_WRITE, 4'd0, 4'd1, 16'hFFFF);
        queue_beat(mfpr_pkg::ACT_WRITE, 4'd1, 4'd15, 16'h1234);
        queue_beat(mfpr_pkg::ACT_WRITE, 4'd1, 4'd1, 16'h00FF);
        queue_beat(mfpr_pkg::ACT_WRITE, 4'd15, 4'd0, 16'hABCD);
        queue_beat(ACT_UNUSED, 4'hF, 4'hF, 16'hFFFF);
        queue_beat(mfpr_pkg::ACT_RUN, 4'hF, 4'hF, 16'hFFFF);
        for (int i = 1; i < 15; i++) queue_beat(mfpr_pkg::ACT_WRITE, 4'd0, 4'(i), 16'hFFFF);
        for (int i = 1; i < 15; i++) queue_beat(mfpr_pkg::ACT_WRITE, 4'(i), 4'd15, 16'hFFFF);
        queue_beat(mfpr_pkg::ACT_RUN, 4'd0, 4'd0, 16'd0);
        queue_beat(mfpr_pkg::ACT_CLEAR, 4'd0, 4'd0, 16'd0);
        queue_beat(mfpr_pkg::ACT_RUN, 4'd0, 4'd0, 16'd0);
        wait_idle();

        // Random phases over a sweep of register settings.
        foreach (cfgs[p]) begin
            write_reg(mfpr_pkg::CFG_NODE_COUNT, 5'(cfgs[p][0]));
            write_reg(mfpr_pkg::CFG_SOURCE, 5'(cfgs[p][1]));
            write_reg(mfpr_pkg::CFG_SINK, 5'(cfgs[p][2]));
            idle_pct = (p == 3) ? 0 : 33;
            queue_random(9);
            wait_idle();
        end

        // Back to a full graph for a last random phase.
        write_reg(mfpr_pkg::CFG_NODE_COUNT, 5'd16);
        write_reg(mfpr_pkg::CFG_SOURCE, 5'd15);
        write_reg(mfpr_pkg::CFG_SINK, 5'd0);
        queue_random(14);
        wait_idle();

        if (failures == 0 && expected_flows.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
